[src/fte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fte_pkg;

	localparam int MAX_SIZE = 1024;
	localparam int POS_W    = 11;
	localparam int DATA_W   = 64;
	localparam int ADDR_W   = $clog2(MAX_SIZE);
	localparam int IDX_W    = POS_W + 1;
	localparam int TOP_STEP = 1 << ($clog2(MAX_SIZE + 1) - 1);
	localparam int UPC_W    = 4;

	typedef logic [UPC_W-1:0]  upc_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [DATA_W-1:0] data_t;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUM = 2'd1,
		FUNC_KTH = 2'd2
	} func_t;

	typedef enum logic [3:0] {
		ACT_IDLE,
		ACT_ADD_INIT,
		ACT_ADD_WALK,
		ACT_SUM_HI,
		ACT_SUM_WALK_ADD,
		ACT_SUM_LO,
		ACT_SUM_WALK_SUB,
		ACT_KTH_INIT,
		ACT_KTH_PROBE,
		ACT_KTH_MOVE,
		ACT_DONE
	} act_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_DISPATCH,
		COND_ADD_ON,
		COND_SUM_ON,
		COND_STEP_LAST,
		COND_OUT_FREE
	} cond_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_WRITE,
		RD_ACC_ADD,
		RD_ACC_SUB,
		RD_PROBE
	} rd_kind_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  jump_hit;
		upc_t  jump_miss;
	} uword_t;

	localparam upc_t UPC_IDLE         = upc_t'(0);
	localparam upc_t UPC_ADD_INIT     = upc_t'(1);
	localparam upc_t UPC_ADD_WALK     = upc_t'(2);
	localparam upc_t UPC_SUM_HI       = upc_t'(3);
	localparam upc_t UPC_SUM_WALK_HI  = upc_t'(4);
	localparam upc_t UPC_SUM_LO       = upc_t'(5);
	localparam upc_t UPC_SUM_WALK_LO  = upc_t'(6);
	localparam upc_t UPC_KTH_INIT     = upc_t'(7);
	localparam upc_t UPC_KTH_PROBE    = upc_t'(8);
	localparam upc_t UPC_KTH_MOVE     = upc_t'(9);
	localparam upc_t UPC_DONE         = upc_t'(10);

	function automatic uword_t ucode(input upc_t upc);
		uword_t w;
		begin
			unique case (upc)
				UPC_IDLE:        w = '{ACT_IDLE,         COND_DISPATCH,  UPC_IDLE,        UPC_IDLE};
				UPC_ADD_INIT:    w = '{ACT_ADD_INIT,     COND_ALWAYS,    UPC_ADD_WALK,    UPC_ADD_WALK};
				UPC_ADD_WALK:    w = '{ACT_ADD_WALK,     COND_ADD_ON,    UPC_ADD_WALK,    UPC_DONE};
				UPC_SUM_HI:      w = '{ACT_SUM_HI,       COND_ALWAYS,    UPC_SUM_WALK_HI, UPC_SUM_WALK_HI};
				UPC_SUM_WALK_HI: w = '{ACT_SUM_WALK_ADD, COND_SUM_ON,    UPC_SUM_WALK_HI, UPC_SUM_LO};
				UPC_SUM_LO:      w = '{ACT_SUM_LO,       COND_ALWAYS,    UPC_SUM_WALK_LO, UPC_SUM_WALK_LO};
				UPC_SUM_WALK_LO: w = '{ACT_SUM_WALK_SUB, COND_SUM_ON,    UPC_SUM_WALK_LO, UPC_DONE};
				UPC_KTH_INIT:    w = '{ACT_KTH_INIT,     COND_ALWAYS,    UPC_KTH_PROBE,   UPC_KTH_PROBE};
				UPC_KTH_PROBE:   w = '{ACT_KTH_PROBE,    COND_ALWAYS,    UPC_KTH_MOVE,    UPC_KTH_MOVE};
				UPC_KTH_MOVE:    w = '{ACT_KTH_MOVE,     COND_STEP_LAST, UPC_DONE,        UPC_KTH_PROBE};
				UPC_DONE:        w = '{ACT_DONE,         COND_OUT_FREE,  UPC_IDLE,        UPC_DONE};
				default:         w = '{ACT_IDLE,         COND_ALWAYS,    UPC_IDLE,        UPC_IDLE};
			endcase
			return w;
		end
	endfunction

	function automatic upc_t dispatch(input logic [1:0] code);
		upc_t t;
		begin
			unique case (code)
				FUNC_ADD: t = UPC_ADD_INIT;
				FUNC_SUM: t = UPC_SUM_HI;
				FUNC_KTH: t = UPC_KTH_INIT;
				default:  t = UPC_DONE;
			endcase
			return t;
		end
	endfunction

	function automatic idx_t low_bit(input idx_t x);
		return x & (~x + idx_t'(1));
	endfunction

endpackage

`default_nettype wire

[src/fte_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module fte_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[src/fenwick_tree_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Binary indexed tree over 1024 signed 64-bit counts, run by a small microcoded
// sequencer over one simple dual-port RAM (one read, one write per cycle).
// Func 0 adds value at first_index, func 1 returns the sum over
// first_index..last_index, func 2 returns the smallest position whose prefix
// reaches value (size+1 if none), func 3 returns zeros; every item gives exactly one result.
// After reset a clearing pass zeroes every tree node, during which in_stall
// is high; active_size writes are taken at any time but belong only to idle
// periods. Add and range-sum walks visit one tree node a cycle, and a k-th
// search spends a probe and a move state per tree level because each level's
// address depends on the data read. A new item is taken only once the last
// has left the sequencer; a finished result waits in the output register
// while the next item runs.

module fenwick_tree_engine (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [1:0]             func,
	input  wire logic [fte_pkg::POS_W-1:0]  first_index,
	input  wire logic [fte_pkg::POS_W-1:0]  last_index,
	input  wire logic [fte_pkg::DATA_W-1:0] value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [fte_pkg::DATA_W-1:0]  sum,
	output logic [fte_pkg::POS_W-1:0]   found_position,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [fte_pkg::POS_W-1:0]  cfg_data
);

	import fte_pkg::*;

	upc_t              upc_q;
	upc_t              upc_nxt;
	uword_t            uw;
	logic              cond_hit;
	logic              in_acc;

	pos_t              active_q;
	idx_t              n_eff;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic [1:0]        op_q;
	pos_t              first_q;
	pos_t              last_q;
	data_t             value_q;
	idx_t              idx_q;
	idx_t              step_q;
	data_t             acc_q;

	idx_t              kth_nxt;
	idx_t              hi_clamp;
	idx_t              lo_clamp;
	idx_t              first_m1;
	logic              add_on;
	logic              sum_on;
	logic              probe_on;

	rd_kind_t          rd_kind;
	rd_kind_t          rd_kind_s1;
	idx_t              rd_idx;
	idx_t              rd_idx_s1;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	data_t             rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	data_t             wr_data;
	logic              probe_less;

	logic              out_valid_q;
	data_t             sum_q;
	pos_t              found_q;
	logic              out_load;

	assign cfg_ready = 1'b1;
	assign in_stall  = clearing_q || (upc_q != UPC_IDLE);
	assign in_acc    = in_valid && !in_stall;

	assign n_eff = (active_q > pos_t'(MAX_SIZE)) ? idx_t'(MAX_SIZE) : {1'b0, active_q};

	assign kth_nxt  = idx_q + step_q;
	assign hi_clamp = ({1'b0, last_q} > n_eff) ? n_eff : {1'b0, last_q};
	assign first_m1 = {1'b0, first_q} - idx_t'(1);
	assign lo_clamp = (first_q == '0) ? '0 : ((first_m1 > n_eff) ? n_eff : first_m1);

	assign add_on   = (idx_q != '0) && (idx_q <= n_eff);
	assign sum_on   = (idx_q != '0);
	assign probe_on = (kth_nxt <= n_eff);

	assign uw = ucode(upc_q);

	always_comb begin
		unique case (uw.cond)
			COND_ALWAYS:    cond_hit = 1'b1;
			COND_DISPATCH:  cond_hit = in_acc;
			COND_ADD_ON:    cond_hit = add_on;
			COND_SUM_ON:    cond_hit = sum_on;
			COND_STEP_LAST: cond_hit = (step_q == idx_t'(1));
			COND_OUT_FREE:  cond_hit = !out_valid_q || !out_stall;
			default:        cond_hit = 1'b0;
		endcase
		if (uw.cond == COND_DISPATCH) begin
			upc_nxt = in_acc ? dispatch(func) : UPC_IDLE;
		end else begin
			upc_nxt = cond_hit ? uw.jump_hit : uw.jump_miss;
		end
	end

	always_comb begin
		rd_kind = RD_NONE;
		rd_idx  = idx_q;
		unique case (uw.act)
			ACT_ADD_WALK: begin
				if (add_on) rd_kind = RD_WRITE;
			end
			ACT_SUM_WALK_ADD: begin
				if (sum_on) rd_kind = RD_ACC_ADD;
			end
			ACT_SUM_WALK_SUB: begin
				if (sum_on) rd_kind = RD_ACC_SUB;
			end
			ACT_KTH_PROBE: begin
				rd_idx = kth_nxt;
				if (probe_on) rd_kind = RD_PROBE;
			end
			default: begin
				rd_kind = RD_NONE;
			end
		endcase
	end

	assign rd_en   = (rd_kind != RD_NONE);
	assign rd_addr = rd_idx[ADDR_W-1:0] - ADDR_W'(1);

	assign probe_less = (rd_kind_s1 == RD_PROBE) && ($signed(rd_data) < $signed(acc_q));

	assign wr_en   = clearing_q || (rd_kind_s1 == RD_WRITE);
	assign wr_addr = clearing_q ? clr_cnt_q : (rd_idx_s1[ADDR_W-1:0] - ADDR_W'(1));
	assign wr_data = clearing_q ? '0 : (rd_data + value_q);

	fte_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_SIZE)
	) u_tree_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q      <= UPC_IDLE;
			rd_kind_s1 <= RD_NONE;
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			active_q   <= pos_t'(1024);
		end else begin
			upc_q      <= upc_nxt;
			rd_kind_s1 <= rd_kind;
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				if (clr_cnt_q == ADDR_W'(MAX_SIZE - 1)) clearing_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) active_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx;
		if (in_acc) begin
			op_q    <= func;
			first_q <= first_index;
			last_q  <= last_index;
			value_q <= value;
		end

		unique case (uw.act)
			ACT_ADD_INIT:     idx_q <= {1'b0, first_q};
			ACT_ADD_WALK:     idx_q <= idx_q + low_bit(idx_q);
			ACT_SUM_HI:       idx_q <= hi_clamp;
			ACT_SUM_WALK_ADD: idx_q <= idx_q - low_bit(idx_q);
			ACT_SUM_LO:       idx_q <= lo_clamp;
			ACT_SUM_WALK_SUB: idx_q <= idx_q - low_bit(idx_q);
			ACT_KTH_INIT: begin
				idx_q  <= '0;
				step_q <= idx_t'(TOP_STEP);
			end
			ACT_KTH_MOVE: begin
				if (probe_less) idx_q <= rd_idx_s1;
				step_q <= step_q >> 1;
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase

		priority if (uw.act == ACT_SUM_HI) begin
			acc_q <= '0;
		end else if (uw.act == ACT_KTH_INIT) begin
			acc_q <= value_q;
		end else if (rd_kind_s1 == RD_ACC_ADD) begin
			acc_q <= acc_q + rd_data;
		end else if (rd_kind_s1 == RD_ACC_SUB || probe_less) begin
			acc_q <= acc_q - rd_data;
		end else begin
			acc_q <= acc_q;
		end

		if (out_load) begin
			sum_q   <= (op_q == FUNC_SUM) ? acc_q : '0;
			found_q <= (op_q == FUNC_KTH) ? (idx_q[POS_W-1:0] + pos_t'(1)) : '0;
		end
	end

	assign out_load = (uw.act == ACT_DONE) && cond_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign sum            = sum_q;
	assign found_position = found_q;

`ifndef SYNTHESIS
	a_clear_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> in_stall)
		else $error("item taken during clearing pass");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_DONE && out_valid_q && out_stall) |=> (upc_q == UPC_DONE))
		else $error("result dropped while output blocked");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write at same tree node");

	a_step_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(upc_q == UPC_KTH_MOVE) |-> $onehot(step_q))
		else $error("k-th step not a power of two");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (upc_q != UPC_IDLE))
		else $error("accepted item not started");
`endif

endmodule

`default_nettype wire
